>>> design/gda_pkg.sv
// shared types, constants and calendar helpers for the gregorian date arithmetic block
`default_nettype none
package gda_pkg;

  localparam int MAX_YEAR_DEF = 9999;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_SUB  = 2'd1;
  localparam logic [1:0] FUNC_DIFF = 2'd2;

  localparam logic [13:0] DEF_YEAR  = 14'd1900;
  localparam logic [21:0] COUNT_MAX = 22'h3FFFFF;

  // floor(2^24 / 100), quotient is exact or one low
  localparam logic [17:0] DIV100_RECIP = 18'd167772;
  localparam int          DIV100_SHIFT = 24;
  // floor(400 * 2^24 / 146097), first guess of the year
  localparam logic [15:0] YEAR_RECIP = 16'd45934;
  localparam int          YEAR_SHIFT = 24;

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [8:0] MONTH_START [13] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_YR_START,
    OP_YR_OTHER,
    OP_YR_NEXT,
    OP_YR_CUR,
    OP_DATE_A,
    OP_DATE_B,
    OP_SUM,
    OP_EST,
    OP_UP,
    OP_DOWN,
    OP_REM,
    OP_MONTH,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic yu_done;
    logic func_ok;
    logic is_diff;
    logic start_ok;
    logic other_ok;
    logic sum_ok;
    logic up_more;
    logic down_more;
    logic month_more;
  } status_t;

  // days from the first day of the calendar to the first day of year max_year + 1
  function automatic int last_days(input int max_year);
    return 365 * max_year + max_year / 4 - max_year / 100 + max_year / 400;
  endfunction

  function automatic int year_width(input int max_year);
    return $clog2(max_year + 3);
  endfunction

  function automatic int day_width(input int max_year);
    return $clog2(last_days(max_year) + 1);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m == 4'd2 && leap) begin
      len = 5'd29;
    end else if (m <= 4'd12) begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    s = 9'd0;
    if (m <= 4'd12) begin
      s = MONTH_START[m] + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> design/gregorian_date_arithmetic.sv
// top level of the gregorian date add, subtract and difference block
//
// one transaction in gives one transaction out. func selects add, subtract
// (day_offset of either sign) or the day count between the start and other
// dates. bad input or an out of range result gives bad_input with 1900-01-01.
// input channel: in_valid / in_stall; in_stall is high while a transaction
// is being worked on, so one transaction is in flight at a time.
// output channel: out_valid / out_stall with a result register; the next
// input transaction is taken while a result still waits to be taken.
// add and subtract run a year search of two or three probes in the shared
// three stage year unit, then a month walk; difference runs neither. a bad
// start date or an out of range add or subtract skips what is left of the
// work. the next input transaction can be taken in the cycle after the
// result register is loaded.
// a stalled output holds its payload; the finished transaction then waits
// in the controller until the result register frees up.
// reset is synchronous; it drops out_valid and returns the controller to
// idle, with no clearing pass.
`default_nettype none
module gregorian_date_arithmetic #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic [13:0]        start_year,
  input  wire logic [3:0]         start_month,
  input  wire logic [4:0]         start_day,
  input  wire logic [13:0]        other_year,
  input  wire logic [3:0]         other_month,
  input  wire logic [4:0]         other_day,
  input  wire logic signed [22:0] day_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [13:0]             result_year,
  output logic [3:0]              result_month,
  output logic [4:0]              result_day,
  output logic [21:0]             day_count,
  output logic                    bad_input
);
  import gda_pkg::*;

  op_t     op;
  status_t st;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .st        (st)
  );

  gda_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .st           (st),
    .func         (func),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .other_year   (other_year),
    .other_month  (other_month),
    .other_day    (other_day),
    .day_offset   (day_offset),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .day_count    (day_count),
    .bad_input    (bad_input)
  );

endmodule
`default_nettype wire

>>> design/gda_year_unit.sv
// three stage unit giving days before a year and its leap flag
`default_nettype none
module gda_year_unit #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          start,
  input  wire logic [gda_pkg::year_width(MAX_YEAR)-1:0]      year,
  output logic                                               done,
  output logic [gda_pkg::day_width(MAX_YEAR)-1:0]            days,
  output logic                                               leap
);
  import gda_pkg::*;

  localparam int YW = year_width(MAX_YEAR);
  localparam int DW = day_width(MAX_YEAR);
  localparam int PW = YW + 18;

  logic          v1;
  logic          v2;
  logic [PW-1:0] prod1;
  logic [YW-1:0] y1;
  logic [YW-1:0] y2;
  logic [YW-1:0] q2;
  logic          rzero2;
  logic          leap2;

  logic [YW-1:0] q0;
  logic [YW-1:0] r0;
  logic [YW-1:0] q_fix;
  logic [YW-1:0] r_fix;
  logic [YW-1:0] pm;
  logic [YW-1:0] qp;
  logic [DW-1:0] pm_w;
  logic [DW-1:0] qp_w;
  logic [DW-1:0] days_calc;

  // quotient and remainder by 100
  always_comb begin
    q0 = YW'(prod1 >> DIV100_SHIFT);
    r0 = y1 - q0 * YW'(100);
    if (r0 >= YW'(100)) begin
      q_fix = q0 + YW'(1);
      r_fix = r0 - YW'(100);
    end else begin
      q_fix = q0;
      r_fix = r0;
    end
  end

  // 365 p + p/4 - p/100 + p/400 with p = year - 1
  always_comb begin
    pm        = y2 - YW'(1);
    qp        = q2 - (rzero2 ? YW'(1) : YW'(0));
    pm_w      = DW'(pm);
    qp_w      = DW'(qp);
    days_calc = pm_w * DW'(365) + (pm_w >> 2) - qp_w + (qp_w >> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    prod1  <= PW'(year) * PW'(DIV100_RECIP);
    y1     <= year;
    y2     <= y1;
    q2     <= q_fix;
    rzero2 <= (r_fix == YW'(0));
    leap2  <= ((y1[1:0] == 2'd0) && (r_fix != YW'(0))) ||
              ((r_fix == YW'(0)) && (q_fix[1:0] == 2'd0));
    days   <= days_calc;
    leap   <= leap2;
  end

endmodule
`default_nettype wire

>>> design/gda_datapath.sv
// datapath: operand registers, date checks, year search and month walk
`default_nettype none
module gda_datapath #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gda_pkg::op_t       op,
  output gda_pkg::status_t        st,
  input  wire logic [1:0]         func,
  input  wire logic [13:0]        start_year,
  input  wire logic [3:0]         start_month,
  input  wire logic [4:0]         start_day,
  input  wire logic [13:0]        other_year,
  input  wire logic [3:0]         other_month,
  input  wire logic [4:0]         other_day,
  input  wire logic signed [22:0] day_offset,
  output logic [13:0]             result_year,
  output logic [3:0]              result_month,
  output logic [4:0]              result_day,
  output logic [21:0]             day_count,
  output logic                    bad_input
);
  import gda_pkg::*;

  localparam int YW        = year_width(MAX_YEAR);
  localparam int DW        = day_width(MAX_YEAR);
  localparam int LAST_DAYS = last_days(MAX_YEAR);
  localparam int SW        = ((DW > 23) ? DW : 23) + 2;
  localparam int CW        = (YW > 14) ? YW : 14;
  localparam int DXW       = (DW > 22) ? DW : 22;
  localparam int EW        = DW + 16;

  logic [1:0]         func_r;
  logic [13:0]        sy;
  logic [3:0]         sm;
  logic [4:0]         sd;
  logic [13:0]        oy;
  logic [3:0]         om;
  logic [4:0]         od;
  logic signed [22:0] off;
  logic               err;
  logic [DW-1:0]      a;
  logic [DW-1:0]      b;
  logic [DW-1:0]      n;
  logic [YW-1:0]      yy;
  logic               leap_r;
  logic [8:0]         rem;
  logic [3:0]         mm;

  logic               yu_start;
  logic [YW-1:0]      yu_year;
  logic               yu_done;
  logic [DW-1:0]      yu_days;
  logic               yu_leap;

  logic [CW-1:0]      sy_w;
  logic [CW-1:0]      oy_w;
  logic [DW-1:0]      a_calc;
  logic [DW-1:0]      b_calc;
  logic signed [SW-1:0] sum;
  logic [EW-1:0]      est_prod;
  logic [EW-1:0]      est;
  logic [4:0]         cur_len;
  logic [DW-1:0]      diff;
  logic [DXW-1:0]     diff_w;
  logic [CW-1:0]      yy_w;

  assign yu_start = (op == OP_YR_START) || (op == OP_YR_OTHER) ||
                    (op == OP_YR_NEXT) || (op == OP_YR_CUR);

  always_comb begin
    case (op)
      OP_YR_START: yu_year = YW'(sy);
      OP_YR_OTHER: yu_year = YW'(oy);
      OP_YR_NEXT:  yu_year = yy + YW'(1);
      default:     yu_year = yy;
    endcase
  end

  gda_year_unit #(
    .MAX_YEAR (MAX_YEAR)
  ) u_year (
    .clk   (clk),
    .rst   (rst),
    .start (yu_start),
    .year  (yu_year),
    .done  (yu_done),
    .days  (yu_days),
    .leap  (yu_leap)
  );

  always_comb begin
    sy_w     = CW'(sy);
    oy_w     = CW'(oy);
    a_calc   = yu_days + DW'(month_start(sm, yu_leap)) + DW'(sd) - DW'(1);
    b_calc   = yu_days + DW'(month_start(om, yu_leap)) + DW'(od) - DW'(1);
    if (func_r == FUNC_SUB) begin
      sum = $signed(SW'(a)) - SW'(off);
    end else begin
      sum = $signed(SW'(a)) + SW'(off);
    end
    est_prod = EW'(n) * EW'(YEAR_RECIP);
    est      = (est_prod >> YEAR_SHIFT) + EW'(1);
    cur_len  = month_len(mm, leap_r);
    diff     = (a > b) ? a - b : b - a;
    diff_w   = DXW'(diff);
    yy_w     = CW'(yy);
  end

  always_comb begin
    st.yu_done    = yu_done;
    st.func_ok    = (func_r == FUNC_ADD) || (func_r == FUNC_SUB) || (func_r == FUNC_DIFF);
    st.is_diff    = (func_r == FUNC_DIFF);
    st.start_ok   = (sy_w >= CW'(1)) && (sy_w <= CW'(MAX_YEAR)) &&
                    (sm >= 4'd1) && (sm <= 4'd12) && (sd != 5'd0) &&
                    (sd <= month_len(sm, yu_leap));
    st.other_ok   = (oy_w >= CW'(1)) && (oy_w <= CW'(MAX_YEAR)) &&
                    (om >= 4'd1) && (om <= 4'd12) && (od != 5'd0) &&
                    (od <= month_len(om, yu_leap));
    st.sum_ok     = (sum >= $signed(SW'(0))) && (sum < $signed(SW'(LAST_DAYS)));
    st.up_more    = (yu_days <= n);
    st.down_more  = (yy > YW'(1)) && (yu_days > n);
    st.month_more = (mm < 4'd12) && (rem >= 9'(cur_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else begin
      case (op)
        OP_LOAD:   err <= 1'b0;
        OP_DATE_A: if (!st.start_ok || !st.func_ok) err <= 1'b1;
        OP_DATE_B: if (!st.other_ok) err <= 1'b1;
        OP_SUM:    if (!st.sum_ok) err <= 1'b1;
        default:   err <= err;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        func_r <= func;
        sy     <= start_year;
        sm     <= start_month;
        sd     <= start_day;
        oy     <= other_year;
        om     <= other_month;
        od     <= other_day;
        off    <= day_offset;
      end
      OP_DATE_A: a <= a_calc;
      OP_DATE_B: b <= b_calc;
      OP_SUM:    n <= sum[DW-1:0];
      OP_EST: begin
        if (est > EW'(MAX_YEAR)) begin
          yy <= YW'(MAX_YEAR);
        end else begin
          yy <= est[YW-1:0];
        end
      end
      OP_UP:   yy <= yy + YW'(1);
      OP_DOWN: yy <= yy - YW'(1);
      OP_REM: begin
        rem    <= 9'(n - yu_days);
        leap_r <= yu_leap;
        mm     <= 4'd1;
      end
      OP_MONTH: begin
        rem <= rem - 9'(cur_len);
        mm  <= mm + 4'd1;
      end
      OP_OUT: begin
        if (err) begin
          result_year  <= DEF_YEAR;
          result_month <= 4'd1;
          result_day   <= 5'd1;
          day_count    <= 22'd0;
          bad_input    <= 1'b1;
        end else if (func_r == FUNC_DIFF) begin
          result_year  <= DEF_YEAR;
          result_month <= 4'd1;
          result_day   <= 5'd1;
          day_count    <= (diff_w > DXW'(COUNT_MAX)) ? COUNT_MAX : diff_w[21:0];
          bad_input    <= 1'b0;
        end else begin
          result_year  <= yy_w[13:0];
          result_month <= mm;
          result_day   <= rem[4:0] + 5'd1;
          day_count    <= 22'd0;
          bad_input    <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/gda_ctrl.sv
// controller state machine sequencing the datapath
`default_nettype none
module gda_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output gda_pkg::op_t          op,
  input  wire gda_pkg::status_t st
);
  import gda_pkg::*;

  typedef enum logic [12:0] {
    IDLE     = 13'b0000000000001,
    A_ISSUE  = 13'b0000000000010,
    A_WAIT   = 13'b0000000000100,
    B_ISSUE  = 13'b0000000001000,
    B_WAIT   = 13'b0000000010000,
    SUM      = 13'b0000000100000,
    EST      = 13'b0000001000000,
    UP_ISSUE = 13'b0000010000000,
    UP_WAIT  = 13'b0000100000000,
    DN_ISSUE = 13'b0001000000000,
    DN_WAIT  = 13'b0010000000000,
    MONTH    = 13'b0100000000000,
    FINISH   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = rst || (state != IDLE);

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    case (state)
      IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = A_ISSUE;
        end
      end
      A_ISSUE: begin
        op         = OP_YR_START;
        state_next = A_WAIT;
      end
      A_WAIT: begin
        if (st.yu_done) begin
          op = OP_DATE_A;
          if (!st.start_ok || !st.func_ok) begin
            state_next = FINISH;
          end else if (st.is_diff) begin
            state_next = B_ISSUE;
          end else begin
            state_next = SUM;
          end
        end
      end
      B_ISSUE: begin
        op         = OP_YR_OTHER;
        state_next = B_WAIT;
      end
      B_WAIT: begin
        if (st.yu_done) begin
          op         = OP_DATE_B;
          state_next = FINISH;
        end
      end
      SUM: begin
        op         = OP_SUM;
        state_next = st.sum_ok ? EST : FINISH;
      end
      EST: begin
        op         = OP_EST;
        state_next = UP_ISSUE;
      end
      UP_ISSUE: begin
        op         = OP_YR_NEXT;
        state_next = UP_WAIT;
      end
      UP_WAIT: begin
        if (st.yu_done) begin
          if (st.up_more) begin
            op         = OP_UP;
            state_next = UP_ISSUE;
          end else begin
            state_next = DN_ISSUE;
          end
        end
      end
      DN_ISSUE: begin
        op         = OP_YR_CUR;
        state_next = DN_WAIT;
      end
      DN_WAIT: begin
        if (st.yu_done) begin
          if (st.down_more) begin
            op         = OP_DOWN;
            state_next = DN_ISSUE;
          end else begin
            op         = OP_REM;
            state_next = MONTH;
          end
        end
      end
      MONTH: begin
        if (st.month_more) begin
          op = OP_MONTH;
        end else begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (!out_valid || !out_stall) begin
          op         = OP_OUT;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
